// ===== hw/rtl/tcpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared types, opcodes and constants of the toy cpu execute unit.
// ----------------------------------------------------------------------------
package tcpu_pkg;

    localparam int MEM_BYTES_DEF = 128;
    localparam int NUM_REGS_DEF  = 6;
    localparam int LINE_W        = 9;
    localparam logic [LINE_W-1:0] LINE_LIMIT = 9'd500;
    localparam logic [LINE_W-1:0] LINE_RESET = 9'd1;

    localparam logic [4:0] OP_MOV_RR  = 5'd0;
    localparam logic [4:0] OP_MOV_RI  = 5'd1;
    localparam logic [4:0] OP_MOV_RM  = 5'd2;
    localparam logic [4:0] OP_MOV_MR  = 5'd3;
    localparam logic [4:0] OP_MOV_IM  = 5'd4;
    localparam logic [4:0] OP_ADD_R   = 5'd5;
    localparam logic [4:0] OP_ADD_I   = 5'd6;
    localparam logic [4:0] OP_ADD_M   = 5'd7;
    localparam logic [4:0] OP_SUB_R   = 5'd8;
    localparam logic [4:0] OP_SUB_I   = 5'd9;
    localparam logic [4:0] OP_SUB_M   = 5'd10;
    localparam logic [4:0] OP_JMP     = 5'd11;
    localparam logic [4:0] OP_JMP_Z   = 5'd12;
    localparam logic [4:0] OP_JPN     = 5'd13;
    localparam logic [4:0] OP_JPN_M   = 5'd14;
    localparam logic [4:0] OP_PRN_R   = 5'd15;
    localparam logic [4:0] OP_PRN_I   = 5'd16;
    localparam logic [4:0] OP_PRN_M   = 5'd17;
    localparam logic [4:0] OP_INP     = 5'd18;
    localparam logic [4:0] OP_HLT     = 5'd19;

    localparam logic [1:0] PK_REG   = 2'd0;
    localparam logic [1:0] PK_CONST = 2'd1;
    localparam logic [1:0] PK_MEM   = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_IMM  = 2'd1;
    localparam logic [1:0] ERR_MEM  = 2'd2;

    typedef struct packed {
        logic [4:0]         operation;
        logic [2:0]         reg_first;
        logic [2:0]         reg_second;
        logic signed [31:0] immediate;
        logic [6:0]         mem_address;
        logic [8:0]         target_line;
        logic signed [7:0]  char_in;
    } t_in_item;

    typedef struct packed {
        logic [8:0]         next_line;
        logic               jumped;
        logic               print_valid;
        logic [1:0]         print_kind;
        logic signed [31:0] print_value;
        logic               halted;
        logic [1:0]         error_code;
    } t_out_item;

    // state updates decided by the execute logic
    typedef struct packed {
        logic              reg_we;
        logic [2:0]        reg_idx;
        logic [31:0]       reg_data;
        logic              mem_we;
        logic [7:0]        mem_data;
        logic [LINE_W-1:0] line_next;
        logic              halt_next;
    } t_exec_ctl;

endpackage

// ===== hw/rtl/tcpu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpu_exec
// Combinational execute logic: one instruction against the fetched operands.
// ----------------------------------------------------------------------------
module tcpu_exec (
    input  tcpu_pkg::t_in_item  i_item,
    input  logic [31:0]         i_ra_val,
    input  logic [31:0]         i_rb_val,
    input  logic [7:0]          i_mem_val,
    input  logic [8:0]          i_line,
    input  logic                i_halt,
    input  logic [8:0]          i_prog_len,
    output tcpu_pkg::t_exec_ctl o_ctl,
    output tcpu_pkg::t_out_item o_res
);
    import tcpu_pkg::*;

    logic        target_ok;
    logic        ra_zero;
    logic        ra_nonpos;
    logic        advance;
    logic        jumped;
    logic [8:0]  jump_to;
    logic [8:0]  mem_target;
    logic [31:0] imm_u;
    logic [31:0] mem_u;
    logic [31:0] ch_s;

    always_comb begin
        target_ok  = (i_item.target_line >= 9'd1) && (i_item.target_line <= i_prog_len);
        ra_zero    = (i_ra_val == 32'd0);
        ra_nonpos  = ra_zero || i_ra_val[31];
        imm_u      = 32'(i_item.immediate);
        mem_u      = {24'd0, i_mem_val};
        mem_target = {1'b0, i_mem_val};
        ch_s       = {{24{i_item.char_in[7]}}, 8'(i_item.char_in)};

        advance  = 1'b1;
        jumped   = 1'b0;
        jump_to  = i_item.target_line;
        o_ctl    = '0;
        o_res    = '0;
        o_ctl.reg_idx   = i_item.reg_first;
        o_ctl.halt_next = i_halt;

        if (i_halt) begin
            advance = 1'b0;
        end else begin
            case (i_item.operation)
                OP_MOV_RR: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_idx  = i_item.reg_second;
                    o_ctl.reg_data = i_ra_val;
                end
                OP_MOV_RI: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = imm_u;
                end
                OP_MOV_RM: begin
                    o_ctl.mem_we   = 1'b1;
                    o_ctl.mem_data = i_ra_val[7:0];
                end
                OP_MOV_MR: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = mem_u;
                end
                OP_MOV_IM: begin
                    o_ctl.mem_we   = 1'b1;
                    o_ctl.mem_data = imm_u[7:0];
                end
                OP_ADD_R: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = i_ra_val + i_rb_val;
                end
                OP_ADD_I: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = i_ra_val + imm_u;
                end
                OP_ADD_M: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = i_ra_val + mem_u;
                end
                OP_SUB_R: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = i_ra_val - i_rb_val;
                end
                OP_SUB_I: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = i_ra_val - imm_u;
                end
                OP_SUB_M: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = i_ra_val - mem_u;
                end
                OP_JMP, OP_JMP_Z, OP_JPN: begin
                    // target is checked even when the branch falls through
                    if (!target_ok) begin
                        o_res.error_code = ERR_IMM;
                        advance          = 1'b0;
                    end else if ((i_item.operation == OP_JMP) ||
                                 (i_item.operation == OP_JMP_Z && ra_zero) ||
                                 (i_item.operation == OP_JPN && ra_nonpos)) begin
                        jumped  = 1'b1;
                        advance = 1'b0;
                    end
                end
                OP_JPN_M: begin
                    if (ra_nonpos) begin
                        advance = 1'b0;
                        if (mem_target > i_prog_len) begin
                            o_res.error_code = ERR_MEM;
                        end else begin
                            jumped  = 1'b1;
                            jump_to = mem_target;
                        end
                    end
                end
                OP_PRN_R: begin
                    o_res.print_valid = 1'b1;
                    o_res.print_kind  = PK_REG;
                    o_res.print_value = i_ra_val;
                end
                OP_PRN_I: begin
                    o_res.print_valid = 1'b1;
                    o_res.print_kind  = PK_CONST;
                    o_res.print_value = i_item.immediate;
                end
                OP_PRN_M: begin
                    o_res.print_valid = 1'b1;
                    o_res.print_kind  = PK_MEM;
                    o_res.print_value = mem_u;
                end
                OP_INP: begin
                    o_ctl.reg_we   = 1'b1;
                    o_ctl.reg_data = ch_s;
                end
                OP_HLT: begin
                    o_ctl.halt_next = 1'b1;
                    advance         = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (jumped) begin
            o_ctl.line_next = jump_to;
        end else if (advance) begin
            o_ctl.line_next = i_line + 9'd1;
        end else begin
            o_ctl.line_next = i_line;
        end

        o_res.next_line = o_ctl.line_next;
        o_res.jumped    = jumped;
        o_res.halted    = o_ctl.halt_next;
    end

endmodule

// ===== hw/rtl/toy_cpu_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit
// Executes one decoded toy-machine instruction per input beat.
// ----------------------------------------------------------------------------
//  channel   signals                          dir  contents
//  in        i_in_valid / o_in_ready / i_in   in   decoded instruction
//  out       o_out_valid / i_out_ready / o_out out  line, jump, print, halt, error
//  cfg       i_cfg_valid / o_cfg_ready / i_cfg_data in program length
//
//  one instruction per cycle unless stalled; beat held in r_in, result in r_out
//  operands are read from the register file and byte memory when the beat is
//  taken and forwarded from the instruction executing in that same cycle
//  reset clears registers, memory valid bits, line counter (1), halt flag and
//  sets program length to 500; no clearing pass is needed
//  a stalled output holds the execute stage, which then backpressures the input
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit #(
    parameter int MEM_BYTES = tcpu_pkg::MEM_BYTES_DEF,
    parameter int NUM_REGS  = tcpu_pkg::NUM_REGS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcpu_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcpu_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [8:0]          i_cfg_data
);
    import tcpu_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = $clog2(NUM_REGS);

    logic [31:0] r_rf [NUM_REGS];
    logic [7:0]  r_mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_mem_vld;

    logic        r_in_valid;
    t_in_item    r_in;
    logic [31:0] r_ra_q;
    logic [31:0] r_rb_q;
    logic [7:0]  r_mem_q;
    logic [8:0]  r_line;
    logic        r_halt;
    logic [8:0]  r_prog_len;
    logic        r_out_valid;
    t_out_item   r_out;

    t_exec_ctl   ctl;
    t_out_item   res;
    logic        exec_fire;
    logic        in_accept;

    logic [4:0]  ra5, rb5, wr5;
    logic        ra_ok, rb_ok, wr_ok;
    logic [8:0]  rd_a9, wr_a9;
    logic        rd_a_ok, wr_a_ok;
    logic        reg_wr, mem_wr;
    logic        fwd_ra, fwd_rb, fwd_mem;

    tcpu_exec u_exec (
        .i_item     (r_in),
        .i_ra_val   (r_ra_q),
        .i_rb_val   (r_rb_q),
        .i_mem_val  (r_mem_q),
        .i_line     (r_line),
        .i_halt     (r_halt),
        .i_prog_len (r_prog_len),
        .o_ctl      (ctl),
        .o_res      (res)
    );

    always_comb begin
        exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
        o_in_ready = !r_in_valid || exec_fire;
        in_accept  = i_in_valid && o_in_ready;

        ra5   = {2'b00, i_in.reg_first};
        rb5   = {2'b00, i_in.reg_second};
        wr5   = {2'b00, ctl.reg_idx};
        ra_ok = ra5 < 5'(NUM_REGS);
        rb_ok = rb5 < 5'(NUM_REGS);
        wr_ok = wr5 < 5'(NUM_REGS);

        rd_a9   = {2'b00, i_in.mem_address};
        wr_a9   = {2'b00, r_in.mem_address};
        rd_a_ok = rd_a9 < 9'(MEM_BYTES);
        wr_a_ok = wr_a9 < 9'(MEM_BYTES);

        reg_wr = exec_fire && ctl.reg_we && wr_ok;
        mem_wr = exec_fire && ctl.mem_we && wr_a_ok;

        // results being written this cycle bypass the arrays
        fwd_ra  = reg_wr && (wr5 == ra5);
        fwd_rb  = reg_wr && (wr5 == rb5);
        fwd_mem = mem_wr && (wr_a9 == rd_a9);
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // control state and register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= LINE_RESET;
            r_halt      <= 1'b0;
            r_prog_len  <= LINE_LIMIT;
            r_mem_vld   <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_prog_len <= (i_cfg_data > LINE_LIMIT) ? LINE_LIMIT : i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_line      <= ctl.line_next;
                r_halt      <= ctl.halt_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (reg_wr) begin
                r_rf[wr5[RW-1:0]] <= ctl.reg_data;
            end
            if (mem_wr) begin
                r_mem_vld[wr_a9[AW-1:0]] <= 1'b1;
            end
        end
    end

    // payload: input stage, operand fetch, byte memory, result register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
            if (!ra_ok) begin
                r_ra_q <= '0;
            end else if (fwd_ra) begin
                r_ra_q <= ctl.reg_data;
            end else begin
                r_ra_q <= r_rf[ra5[RW-1:0]];
            end
            if (!rb_ok) begin
                r_rb_q <= '0;
            end else if (fwd_rb) begin
                r_rb_q <= ctl.reg_data;
            end else begin
                r_rb_q <= r_rf[rb5[RW-1:0]];
            end
            if (!rd_a_ok) begin
                r_mem_q <= '0;
            end else if (fwd_mem) begin
                r_mem_q <= ctl.mem_data;
            end else if (!r_mem_vld[rd_a9[AW-1:0]]) begin
                r_mem_q <= '0;
            end else begin
                r_mem_q <= r_mem[rd_a9[AW-1:0]];
            end
        end
        if (mem_wr) begin
            r_mem[wr_a9[AW-1:0]] <= ctl.mem_data;
        end
        if (exec_fire) begin
            r_out <= res;
        end
    end

endmodule
